// ----- hdl/spd_pkg.sv -----
// Shared types and constants of the sorted priority deque.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package spd_pkg;

  localparam int VALUE_W        = 16;
  localparam int PRIO_W         = 16;
  localparam int REQ_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 7;
  localparam int DEF_LIST_DEPTH = 64;
  localparam int DEF_VALUE_BITS = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT_SORTED = 3'd0,
    REQ_INSERT_FRONT  = 3'd1,
    REQ_INSERT_BACK   = 3'd2,
    REQ_REMOVE_FRONT  = 3'd3,
    REQ_REMOVE_BACK   = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/spd_cell.sv -----
// One storage cell of the deque chain: holds a value and priority pair.
// Depends on spd_pkg for the cell command type and the priority width.
`default_nettype none
module spd_cell
  import spd_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                   clk,
  input  wire cell_cmd_t        cmd,
  input  wire  [VALUE_BITS-1:0] new_value,
  input  wire  [PRIO_W-1:0]     new_prio,
  input  wire  [VALUE_BITS-1:0] left_value,
  input  wire  [PRIO_W-1:0]     left_prio,
  input  wire  [VALUE_BITS-1:0] right_value,
  input  wire  [PRIO_W-1:0]     right_prio,
  output logic [VALUE_BITS-1:0] value,
  output logic [PRIO_W-1:0]     prio,
  output logic                  lt
);

  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [PRIO_W-1:0]     prio_r, prio_nxt;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    priority if (cmd.load) begin
      value_nxt = new_value;
      prio_nxt  = new_prio;
    end else if (cmd.from_left) begin
      value_nxt = left_value;
      prio_nxt  = left_prio;
    end else if (cmd.from_right) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value = value_r;
  assign prio  = prio_r;
  assign lt    = new_prio < prio_r;

endmodule
`default_nettype wire

// ----- hdl/spd_ctrl.sv -----
// Request decoder, entry counter and result status of the deque.
// Finds the insertion point from the cell compare flags and drives the cell commands.
// Depends on spd_pkg.
`default_nettype none
module spd_ctrl
  import spd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  input  wire  [REQ_W-1:0]      req_type,
  input  wire  [LIST_DEPTH-1:0] lt,
  output logic                  busy,
  output cell_cmd_t             cmd [LIST_DEPTH],
  output logic [CNT_W-1:0]      count,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status
);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  status_t               out_status_r, status_nxt;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  shift_down;
  logic [LIST_DEPTH-1:0] occ;
  logic [LIST_DEPTH-1:0] hit;
  logic [LIST_DEPTH-1:0] hit_neg;
  logic [LIST_DEPTH-1:0] first_hit;
  logic [LIST_DEPTH-1:0] past_hit;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_r == CNT_W'(LIST_DEPTH);
  assign empty  = count_r == '0;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      occ[i] = CNT_W'(i) < count_r;
    end
  end

  always_comb begin
    hit        = '0;
    shift_down = 1'b0;
    count_nxt  = count_r;
    status_nxt = STATUS_DONE;
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_INSERT_SORTED, REQ_INSERT_FRONT, REQ_INSERT_BACK: begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            unique case (req_t'(req_type))
              REQ_INSERT_SORTED: hit = lt | ~occ;
              REQ_INSERT_FRONT:  hit = '1;
              default:           hit = ~occ;
            endcase
          end
        end
        REQ_REMOVE_FRONT, REQ_REMOVE_BACK: begin
          if (empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            count_nxt  = count_r - CNT_W'(1);
            shift_down = req_t'(req_type) == REQ_REMOVE_FRONT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The lowest set bit of the hit vector marks the new entry's slot; every
  // cell above it takes its lower neighbor.
  assign hit_neg   = ~hit + LIST_DEPTH'(1);
  assign first_hit = hit & hit_neg;
  assign past_hit  = (hit | hit_neg) & ~first_hit;

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cmd[i].load       = first_hit[i];
      cmd[i].from_left  = past_hit[i];
      cmd[i].from_right = shift_down;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STATUS_DONE;
    end else begin
      count_r      <= count_nxt;
      out_valid_r  <= accept;
      out_status_r <= status_nxt;
    end
  end

  assign count      = count_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_deque.sv -----
// Top level of the sorted priority deque: a chain of entry cells and its controller.
// Depends on spd_pkg, spd_cell and spd_ctrl.
//
//   Channel   Ports                                  Transaction
//   request   start, busy, in_*                      start high and busy low at a clock edge
//   result    out_valid, out_*                       out_valid high for one cycle
//
// A request is accepted in every cycle; busy never rises.
// The result of a request shows in the cycle right after its acceptance.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
// Each request takes one compare in every cell, the carry chain
// across the cells that finds the insertion slot, and one shift of the chain.
// Reset empties the list at once; entry contents are not cleared.
`default_nettype none
module sorted_priority_deque
  import spd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  [REQ_W-1:0]    in_req_type,
  input  wire  [VALUE_W-1:0]  in_item_value,
  input  wire  [PRIO_W-1:0]   in_item_priority,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [VALUE_W-1:0]  out_head_value,
  output logic [PRIO_W-1:0]   out_head_priority,
  output logic                out_head_valid,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  cell_cmd_t             cmd [LIST_DEPTH];
  logic [VALUE_BITS-1:0] cell_value [LIST_DEPTH];
  logic [PRIO_W-1:0]     cell_prio [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] lt;
  logic [CNT_W-1:0]      count;
  logic [VALUE_BITS-1:0] new_value;

  assign new_value = VALUE_BITS'(in_item_value);

  spd_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_req_type),
    .lt        (lt),
    .busy      (busy),
    .cmd       (cmd),
    .count     (count),
    .out_valid (out_valid),
    .out_status(out_status)
  );

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    spd_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd[i]),
      .new_value  (new_value),
      .new_prio   (in_item_priority),
      .left_value (cell_value[(i == 0) ? 0 : i - 1]),
      .left_prio  (cell_prio[(i == 0) ? 0 : i - 1]),
      .right_value(cell_value[(i == LIST_DEPTH - 1) ? i : i + 1]),
      .right_prio (cell_prio[(i == LIST_DEPTH - 1) ? i : i + 1]),
      .value      (cell_value[i]),
      .prio       (cell_prio[i]),
      .lt         (lt[i])
    );
  end

  assign out_head_valid    = count != '0;
  assign out_head_value    = out_head_valid ? VALUE_W'(cell_value[0]) : '0;
  assign out_head_priority = out_head_valid ? cell_prio[0] : '0;
  assign out_entry_count   = COUNT_W'(count);

endmodule
`default_nettype wire

// ----- hdl/spd_checker.sv -----
// Port-level checks of the sorted priority deque, bound to its top level.
// Depends on spd_pkg and sorted_priority_deque.
`default_nettype none
module spd_checker
  import spd_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input wire                clk,
  input wire                rst_n,
  input wire                start,
  input wire                busy,
  input wire                out_valid,
  input wire [STATUS_W-1:0] out_status,
  input wire [VALUE_W-1:0]  out_head_value,
  input wire [PRIO_W-1:0]   out_head_priority,
  input wire                out_head_valid,
  input wire [COUNT_W-1:0]  out_entry_count
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("Accepted transaction produced no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("Result appeared without an accepted transaction.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |->
      (out_entry_count == COUNT_W'(LIST_DEPTH) && out_head_valid))
    else $error("Full status reported while the list is not full.");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_EMPTY) |->
      (out_entry_count == '0 && !out_head_valid))
    else $error("Empty status reported while the list holds entries.");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_head_valid) |->
      (out_head_value == '0 && out_head_priority == '0))
    else $error("Head fields are not zero on an empty list.");

endmodule

bind sorted_priority_deque spd_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_spd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_head_value   (out_head_value),
  .out_head_priority(out_head_priority),
  .out_head_valid   (out_head_valid),
  .out_entry_count  (out_entry_count)
);
`default_nettype wire
